// ===== sv/sparse_tile_accumulator_core_defines.svh =====
// Assertion macros for the sparse tile accumulator checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SPARSE_TILE_ACCUMULATOR_CORE_DEFINES_SVH
`define SPARSE_TILE_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, skipped while reset is asserted.
`define STAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define STAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/stac_pkg.sv =====
// Shared types and constants of the sparse tile accumulator.
// No dependencies; imported by every module of the block.
package stac_pkg;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int VALUE_WIDTH = 32;

    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int POS_W    = 6;
    localparam int TILE_CAP = 64;
    localparam int CNT_W    = 7;

    typedef logic signed [VALUE_WIDTH-1:0] t_sum;

    typedef struct packed {
        logic              end_of_matrix;
        logic [ROW_W-1:0]  in_row;
        logic [COL_W-1:0]  in_col;
        logic signed [31:0] in_value;
    } t_in_beat;

    typedef struct packed {
        logic [ROW_W-1:0]  out_row;
        logic [COL_W-1:0]  out_col;
        logic signed [31:0] out_sum;
        logic              last_entry;
        logic              no_entries;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic elem_wr;      // accepted in-range element
        logic drain_start;  // rewind the order-list index
        logic sum_rd;       // drain: read sum at listed position, clear its touch bit
        logic out_load;     // load a drained entry into the output register
        logic out_empty;    // load the empty-tile beat
        logic idx_inc;      // advance to next listed position
        logic cnt_clear;    // drain finished
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_eom;
        logic in_range;
        logic cnt_zero;
        logic idx_last;
    } t_dp_sts;

endpackage

// ===== sv/stac_dp.sv =====
// Datapath: sum memory with read-modify-write and forwarding, touch map,
// first-touch order list and output register. Depends on stac_pkg.
module stac_dp import stac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in_beat,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_beat o_out_beat
);

    t_sum mem_sum [TILE_CAP];
    logic [ROW_W+COL_W-1:0] mem_ord [TILE_CAP];

    logic [TILE_CAP-1:0] r_touch;
    logic [CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]    r_idx;
    logic                r_s1_vld;

    logic [POS_W-1:0]       r_s1_pos;
    t_sum                   r_s1_val;
    logic                   r_s1_touch;
    logic                   r_s1_fwd;
    t_sum                   r_wb_sum;
    t_sum                   r_rd;
    logic [ROW_W+COL_W-1:0] r_ord;
    t_out_beat              r_out;

    logic [POS_W-1:0] pos_in;
    logic [POS_W-1:0] pos_dr;
    logic [POS_W-1:0] rd_addr;
    logic [ROW_W-1:0] dr_row;
    logic [COL_W-1:0] dr_col;
    t_sum             val_in;
    t_sum             old_sum;
    t_sum             new_sum;
    logic             first_touch;

    assign dr_row  = r_ord[ROW_W+COL_W-1:COL_W];
    assign dr_col  = r_ord[COL_W-1:0];
    assign pos_in  = POS_W'(POS_W'(i_in_beat.in_row) * POS_W'(COLS))
                   + POS_W'(i_in_beat.in_col);
    assign pos_dr  = POS_W'(POS_W'(dr_row) * POS_W'(COLS)) + POS_W'(dr_col);
    assign rd_addr = i_cmd.sum_rd ? pos_dr : pos_in;
    assign val_in  = VALUE_WIDTH'(i_in_beat.in_value);

    // untouched entries read as zero; back-to-back hits take the last write
    assign old_sum = !r_s1_touch ? '0 : (r_s1_fwd ? r_wb_sum : r_rd);
    assign new_sum = old_sum + r_s1_val;

    assign first_touch = !r_touch[pos_in] && (r_cnt < CNT_W'(TILE_CAP));

    assign o_sts.in_eom   = i_in_beat.end_of_matrix;
    assign o_sts.in_range = ({1'b0, i_in_beat.in_row} < (ROW_W+1)'(ROWS))
                         && ({1'b0, i_in_beat.in_col} < (COL_W+1)'(COLS));
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.idx_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_cnt);

    assign o_out_beat = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch  <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.elem_wr;
            if (i_cmd.elem_wr && first_touch) begin
                r_touch[pos_in] <= 1'b1;
                r_cnt           <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.sum_rd) begin
                r_touch[pos_dr] <= 1'b0;
            end
            if (i_cmd.drain_start) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + POS_W'(1);
            end
            if (i_cmd.cnt_clear) begin
                r_cnt <= '0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            mem_sum[r_s1_pos] <= new_sum;
        end
        if (i_cmd.elem_wr || i_cmd.sum_rd) begin
            r_rd <= mem_sum[rd_addr];
        end
        if (i_cmd.elem_wr && first_touch) begin
            mem_ord[r_cnt[POS_W-1:0]] <= {i_in_beat.in_row, i_in_beat.in_col};
        end
        r_ord <= mem_ord[r_idx];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_wb_sum <= new_sum;
        end
        if (i_cmd.elem_wr) begin
            r_s1_pos   <= pos_in;
            r_s1_val   <= val_in;
            r_s1_touch <= r_touch[pos_in];
            r_s1_fwd   <= r_s1_vld && (r_s1_pos == pos_in);
        end
        if (i_cmd.out_load) begin
            r_out.out_row    <= dr_row;
            r_out.out_col    <= dr_col;
            r_out.out_sum    <= 32'(r_rd);
            r_out.last_entry <= o_sts.idx_last;
            r_out.no_entries <= 1'b0;
        end else if (i_cmd.out_empty) begin
            r_out.out_row    <= '0;
            r_out.out_col    <= '0;
            r_out.out_sum    <= '0;
            r_out.last_entry <= 1'b0;
            r_out.no_entries <= 1'b1;
        end
    end

endmodule

// ===== sv/stac_ctrl.sv =====
// Controller: accepts beats in idle and sequences the drain of a tile.
// Depends on stac_pkg; drives the datapath through t_dp_cmd.
module stac_ctrl import stac_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMPTY,
        S_LIST,
        S_SUM,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_sts.in_eom) begin
                        o_cmd.elem_wr = i_sts.in_range;
                    end else if (i_sts.cnt_zero) begin
                        n_state = S_EMPTY;
                    end else begin
                        o_cmd.drain_start = 1'b1;
                        n_state           = S_LIST;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    o_cmd.out_empty = 1'b1;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_LIST: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_rd = 1'b1;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    if (i_sts.idx_last) begin
                        o_cmd.cnt_clear = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_LIST;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/sparse_tile_accumulator_core.sv =====
// Sparse tile accumulator, top level: controller plus datapath.
// Depends on stac_pkg, stac_ctrl and stac_dp.
//
// Input channel (i_in_valid / o_in_stall / i_in_beat): each beat is either an
// element (row, col, signed value) or an end-of-matrix marker. Elements are
// summed with two's-complement wrap into an 8x8 tile of sums; out-of-tile
// positions are dropped. While not stalled, element beats go at one per cycle:
// a one-stage read-modify-write on the sum memory, forwarding repeated hits.
// An end-of-matrix beat drains the tile: each touched position is sent once,
// in first-touch order, with last_entry on the final beat, and is cleared.
// An empty tile gives one beat with no_entries set and all else zero.
// Drain: each result takes an order-list read, a sum read and an output load
// in turn, and one result is drained at a time; o_in_stall stays
// high for the whole drain. Output channel (o_out_valid / i_out_stall /
// o_out_beat) is a single output register; while i_out_stall is high the beat
// holds and the drain waits. Element beats are still taken while the last
// result waits. Synchronous reset empties the tile (touch map and count
// cleared, untouched sums read as zero) and drops any pending output.
module sparse_tile_accumulator_core import stac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    stac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    stac_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_beat  (i_in_beat),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_beat (o_out_beat)
    );

endmodule

// ===== sv/stac_chk.sv =====
// Port-level checker for the sparse tile accumulator, bound to the top level.
// Depends on stac_pkg and sparse_tile_accumulator_core_defines.svh.
`include "sparse_tile_accumulator_core_defines.svh"

module stac_chk import stac_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    `STAC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "out beat dropped")
    `STAC_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_beat), "out beat moved")
    `STAC_ASSERT_SAME(a_empty_beat, o_out_valid && o_out_beat.no_entries, !o_out_beat.last_entry && (o_out_beat.out_row == '0) && (o_out_beat.out_col == '0) && (o_out_beat.out_sum == '0), "empty beat not clean")
    `STAC_ASSERT_NEXT(a_drain_on, o_out_valid && !i_out_stall && !o_out_beat.last_entry && !o_out_beat.no_entries, o_out_valid || o_in_stall, "drain quit early")

endmodule

bind sparse_tile_accumulator_core stac_chk u_stac_chk (.*);
